FILE: rtl/core/wadat_pkg.sv
// Package for the windowed ADC average / threshold unit.
// Holds widths, command and register codes, and the divider handshake types.
// No dependencies.
`default_nettype none

package wadat_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 12;
    localparam int DUR_W    = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // sample counter covers press_duration / 1 at worst
    localparam int CNT_W  = DUR_W;
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int TICK_W = 4;

    localparam int DIV_STEP_W = $clog2(SUM_W + 1);

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_TICK  = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_CHANNEL_A_ENABLE = 2'd0,
        REG_CHANNEL_B_ENABLE = 2'd1,
        REG_PRESS_DURATION   = 2'd2,
        REG_PRESS_THRESHOLD  = 2'd3
    } cfg_idx_t;

    typedef struct packed
    {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_ctrl_t;

    typedef struct packed
    {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/wadat_in_if.sv
// Input channel: start / tick words with both channel samples.
// Depends on wadat_pkg.
`default_nettype none

interface wadat_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [wadat_pkg::SAMPLE_W-1:0] sample_a;
    logic [wadat_pkg::SAMPLE_W-1:0] sample_b;

    modport source (output valid, output command, output sample_a, output sample_b,
                    input ready);
    modport sink   (input valid, input command, input sample_a, input sample_b,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/wadat_out_if.sv
// Result channel: both averages and the pressed flag.
// Depends on wadat_pkg.
`default_nettype none

interface wadat_out_if;
    logic                          valid;
    logic                          ready;
    logic [wadat_pkg::SAMPLE_W-1:0] average_a;
    logic [wadat_pkg::SAMPLE_W-1:0] average_b;
    logic                          pressed;

    modport source (output valid, output average_a, output average_b, output pressed,
                    input ready);
    modport sink   (input valid, input average_a, input average_b, input pressed,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/core/wadat_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on wadat_pkg.
`default_nettype none

interface wadat_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [wadat_pkg::CFG_IDX_W-1:0] index;
    logic [wadat_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/wadat_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on wadat_pkg (widths, div_ctrl_t, div_stat_t).
`default_nettype none

module wadat_div
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire wadat_pkg::div_ctrl_t ctrl,
    output wadat_pkg::div_stat_t      stat
);

    localparam int SUM_W  = wadat_pkg::SUM_W;
    localparam int CNT_W  = wadat_pkg::CNT_W;
    localparam int STEP_W = wadat_pkg::DIV_STEP_W;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  shift_reg, shift_next;
    logic [CNT_W-1:0]  divisor_reg, divisor_next;

    logic [CNT_W:0]    partial;
    logic [CNT_W+1:0]  diff;
    logic              fits;

    // shift the next dividend bit into the remainder and try a subtract
    assign partial = {rem_reg, shift_reg[SUM_W-1]};
    assign diff    = {1'b0, partial} - {2'b00, divisor_reg};
    assign fits    = ~diff[CNT_W+1];

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        rem_next     = rem_reg;
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        if (ctrl.start)
        begin
            busy_next    = 1'b1;
            step_next    = '0;
            rem_next     = '0;
            shift_next   = ctrl.dividend;
            divisor_next = ctrl.divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[CNT_W-1:0] : partial[CNT_W-1:0];
            shift_next = {shift_reg[SUM_W-2:0], fits};
            step_next  = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = shift_reg;

endmodule

`default_nettype wire

FILE: rtl/core/windowed_adc_average_threshold_unit.sv
// Two-channel windowed ADC average with a press threshold. A start word latches the channel
// enables and press_duration and sets the target sample count, press_duration / SAMPLE_PERIOD
// (at least 1), through a constant reciprocal multiply. Tick words are then taken back to
// back; every SAMPLE_PERIOD ticks the enabled samples are added to the running sums. The tick
// that completes the window holds the input off while one shared 28-step serial divider runs
// twice, once per channel sum, and the result word goes to an output register that frees the
// input side. A start with both channels disabled answers with zero averages and no division,
// and also holds the input until its word reaches the output register. Either result waits
// while the output register still holds an unread word. A start while a window is open
// restarts it; ticks while idle are dropped.
// Depends on wadat_pkg, wadat_in_if, wadat_out_if, wadat_cfg_if and wadat_div.
`default_nettype none

module windowed_adc_average_threshold_unit
#(
    parameter int SAMPLE_PERIOD = 10,
    parameter int SAMPLE_BITS   = 12
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    wadat_in_if.sink     sample_ch,
    wadat_out_if.source  result_ch,
    wadat_cfg_if.sink    cfg
);

    localparam int SAMPLE_W = wadat_pkg::SAMPLE_W;
    localparam int CNT_W    = wadat_pkg::CNT_W;
    localparam int SUM_W    = wadat_pkg::SUM_W;
    localparam int TICK_W   = wadat_pkg::TICK_W;
    localparam int DUR_W    = wadat_pkg::DUR_W;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK =
        SAMPLE_W'((33'd1 << SAMPLE_BITS) - 33'd1);
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(SAMPLE_PERIOD - 1);

    // duration / SAMPLE_PERIOD as (duration * ceil(2^k / SAMPLE_PERIOD)) >> k,
    // exact over the whole duration range with k = DUR_W + clog2(SAMPLE_PERIOD)
    localparam int TGT_SHIFT = DUR_W + $clog2(SAMPLE_PERIOD);
    localparam int PROD_W    = TGT_SHIFT + CNT_W;
    localparam logic [DUR_W:0] TGT_RECIP =
        (DUR_W+1)'(((64'd1 << TGT_SHIFT) + 64'(SAMPLE_PERIOD) - 64'd1) / 64'(SAMPLE_PERIOD));

    typedef enum logic [4:0]
    {
        S_IDLE = 5'b00001,
        S_RUN  = 5'b00010,
        S_DIVA = 5'b00100,
        S_DIVB = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    // configuration registers
    logic                en_a_cfg_reg;
    logic                en_b_cfg_reg;
    logic [DUR_W-1:0]    duration_reg;
    logic [SAMPLE_W-1:0] threshold_reg;

    state_t              state_reg, state_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [CNT_W-1:0]    target_reg, target_next;
    logic [CNT_W-1:0]    taken_reg, taken_next;
    logic [SUM_W-1:0]    sum_a_reg, sum_a_next;
    logic [SUM_W-1:0]    sum_b_reg, sum_b_next;
    logic                run_en_a_reg, run_en_a_next;
    logic                run_en_b_reg, run_en_b_next;
    logic [SAMPLE_W-1:0] avg_a_reg, avg_a_next;
    logic [SAMPLE_W-1:0] avg_b_reg, avg_b_next;
    logic                hit_a_reg, hit_a_next;
    logic                hit_b_reg, hit_b_next;
    logic                div_start_reg, div_start_next;

    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_avg_a_reg, out_avg_a_next;
    logic [SAMPLE_W-1:0] out_avg_b_reg, out_avg_b_next;
    logic                out_pressed_reg, out_pressed_next;

    logic                in_fire;
    logic                out_free;
    logic [SAMPLE_W-1:0] sa_masked;
    logic [SAMPLE_W-1:0] sb_masked;
    logic [CNT_W-1:0]    taken_inc;
    logic [PROD_W-1:0]   tgt_prod;
    logic [CNT_W-1:0]    tgt_quot;
    logic                quot_over;

    wadat_pkg::div_ctrl_t div_ctrl;
    wadat_pkg::div_stat_t div_stat;

    wadat_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (div_ctrl),
        .stat  (div_stat)
    );

    assign sample_ch.ready = (state_reg inside {S_IDLE, S_RUN});
    assign in_fire   = sample_ch.valid & sample_ch.ready;
    assign out_free  = ~out_valid_reg | result_ch.ready;
    assign sa_masked = sample_ch.sample_a & SAMPLE_MASK;
    assign sb_masked = sample_ch.sample_b & SAMPLE_MASK;
    assign taken_inc = taken_reg + CNT_W'(1);
    assign tgt_prod  = PROD_W'(duration_reg) * PROD_W'(TGT_RECIP);
    assign tgt_quot  = tgt_prod[TGT_SHIFT +: CNT_W];
    assign quot_over = (div_stat.quotient > SUM_W'(threshold_reg));

    // divider operands follow the state
    always_comb
    begin
        div_ctrl.start   = div_start_reg;
        div_ctrl.divisor = taken_reg;
        case (state_reg)
            S_DIVA:
            begin
                div_ctrl.dividend = sum_a_reg;
            end
            default:
            begin
                div_ctrl.dividend = sum_b_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        tick_next        = tick_reg;
        target_next      = target_reg;
        taken_next       = taken_reg;
        sum_a_next       = sum_a_reg;
        sum_b_next       = sum_b_reg;
        run_en_a_next    = run_en_a_reg;
        run_en_b_next    = run_en_b_reg;
        avg_a_next       = avg_a_reg;
        avg_b_next       = avg_b_reg;
        hit_a_next       = hit_a_reg;
        hit_b_next       = hit_b_reg;
        div_start_next   = 1'b0;
        out_valid_next   = out_valid_reg & ~result_ch.ready;
        out_avg_a_next   = out_avg_a_reg;
        out_avg_b_next   = out_avg_b_reg;
        out_pressed_next = out_pressed_reg;

        case (state_reg)
            S_IDLE, S_RUN:
            begin
                if (in_fire)
                begin
                    if (sample_ch.command == wadat_pkg::CMD_START)
                    begin
                        tick_next     = '0;
                        taken_next    = '0;
                        sum_a_next    = '0;
                        sum_b_next    = '0;
                        target_next   = (tgt_quot == '0) ? CNT_W'(1) : tgt_quot;
                        run_en_a_next = en_a_cfg_reg;
                        run_en_b_next = en_b_cfg_reg;
                        if (!en_a_cfg_reg && !en_b_cfg_reg)
                        begin
                            avg_a_next = '0;
                            avg_b_next = '0;
                            hit_a_next = 1'b0;
                            hit_b_next = 1'b0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RUN;
                        end
                    end
                    else if (state_reg == S_RUN)
                    begin
                        if (tick_reg == TICK_LAST)
                        begin
                            tick_next  = '0;
                            taken_next = taken_inc;
                            if (run_en_a_reg)
                            begin
                                sum_a_next = sum_a_reg + SUM_W'(sa_masked);
                            end
                            if (run_en_b_reg)
                            begin
                                sum_b_next = sum_b_reg + SUM_W'(sb_masked);
                            end
                            // window closes on the last sample
                            if (taken_inc == target_reg)
                            begin
                                div_start_next = 1'b1;
                                state_next     = S_DIVA;
                            end
                        end
                        else
                        begin
                            tick_next = tick_reg + TICK_W'(1);
                        end
                    end
                end
            end
            S_DIVA:
            begin
                if (div_stat.done)
                begin
                    avg_a_next     = run_en_a_reg ? div_stat.quotient[SAMPLE_W-1:0] : '0;
                    hit_a_next     = run_en_a_reg & quot_over;
                    div_start_next = 1'b1;
                    state_next     = S_DIVB;
                end
            end
            S_DIVB:
            begin
                if (div_stat.done)
                begin
                    avg_b_next = run_en_b_reg ? div_stat.quotient[SAMPLE_W-1:0] : '0;
                    hit_b_next = run_en_b_reg & quot_over;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // hold until the output register can take the word
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_avg_a_next   = avg_a_reg;
                    out_avg_b_next   = avg_b_reg;
                    out_pressed_next = hit_a_reg | hit_b_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tick_reg      <= '0;
            target_reg    <= CNT_W'(1);
            taken_reg     <= '0;
            run_en_a_reg  <= 1'b0;
            run_en_b_reg  <= 1'b0;
            div_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            target_reg    <= target_next;
            taken_reg     <= taken_next;
            run_en_a_reg  <= run_en_a_next;
            run_en_b_reg  <= run_en_b_next;
            div_start_reg <= div_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_a_reg       <= sum_a_next;
        sum_b_reg       <= sum_b_next;
        avg_a_reg       <= avg_a_next;
        avg_b_reg       <= avg_b_next;
        hit_a_reg       <= hit_a_next;
        hit_b_reg       <= hit_b_next;
        out_avg_a_reg   <= out_avg_a_next;
        out_avg_b_reg   <= out_avg_b_next;
        out_pressed_reg <= out_pressed_next;
    end

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_a_cfg_reg  <= 1'b1;
            en_b_cfg_reg  <= 1'b1;
            duration_reg  <= DUR_W'(100);
            threshold_reg <= SAMPLE_W'(3000);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                wadat_pkg::REG_CHANNEL_A_ENABLE: en_a_cfg_reg  <= cfg.data[0];
                wadat_pkg::REG_CHANNEL_B_ENABLE: en_b_cfg_reg  <= cfg.data[0];
                wadat_pkg::REG_PRESS_DURATION:   duration_reg  <= cfg.data[DUR_W-1:0];
                wadat_pkg::REG_PRESS_THRESHOLD:  threshold_reg <= cfg.data[SAMPLE_W-1:0];
                default:                         ;
            endcase
        end
    end

    assign result_ch.valid     = out_valid_reg;
    assign result_ch.average_a = out_avg_a_reg;
    assign result_ch.average_b = out_avg_b_reg;
    assign result_ch.pressed   = out_pressed_reg;

endmodule

`default_nettype wire
